@@ sv/cbz_pkg.sv @@
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared types and constants of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbz_pkg;

	// pipeline depth: level-1 lerp, level-2 product, level-2 sum,
	// level-3 product, level-3 sum with pixel rounding
	localparam int NUM_STAGES   = 5;
	localparam int NUM_CTRL_PTS = 4;
	localparam int CFG_IDX_W    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P0_X = 3'd0,
		REG_P0_Y = 3'd1,
		REG_P1_X = 3'd2,
		REG_P1_Y = 3'd3,
		REG_P2_X = 3'd4,
		REG_P2_Y = 3'd5,
		REG_P3_X = 3'd6,
		REG_P3_Y = 3'd7
	} cfg_reg_t;

	// per-stage load strobes shared by both axis datapaths
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} pipe_ctl_t;

endpackage

`default_nettype wire

@@ sv/cbz_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cbz_cfg_regs
// Control point register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_cfg_regs #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            cfg_wen,
	input  wire logic [cbz_pkg::CFG_IDX_W-1:0]                   cfg_idx,
	input  wire logic [COORD_BITS-1:0]                           cfg_wdata,
	output logic      [cbz_pkg::NUM_CTRL_PTS-1:0][COORD_BITS-1:0] ctrl_x,
	output logic      [cbz_pkg::NUM_CTRL_PTS-1:0][COORD_BITS-1:0] ctrl_y
);
	import cbz_pkg::*;

	logic [NUM_CTRL_PTS-1:0][COORD_BITS-1:0] x_q;
	logic [NUM_CTRL_PTS-1:0][COORD_BITS-1:0] y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_idx))
				REG_P0_X: x_q[0] <= cfg_wdata;
				REG_P0_Y: y_q[0] <= cfg_wdata;
				REG_P1_X: x_q[1] <= cfg_wdata;
				REG_P1_Y: y_q[1] <= cfg_wdata;
				REG_P2_X: x_q[2] <= cfg_wdata;
				REG_P2_Y: y_q[2] <= cfg_wdata;
				REG_P3_X: x_q[3] <= cfg_wdata;
				REG_P3_Y: y_q[3] <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign ctrl_x = x_q;
	assign ctrl_y = y_q;

endmodule

`default_nettype wire

@@ sv/cbz_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbz_pipe_ctrl
// Valid bits, per-stage load strobes and the t register line of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_pipe_ctrl #(
	parameter int T_FRAC_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [T_FRAC_BITS:0]   in_t,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output cbz_pkg::pipe_ctl_t          ctl,
	output logic      [T_FRAC_BITS:0]   t_sat,
	output logic      [T_FRAC_BITS:0]   t_s1,
	output logic      [T_FRAC_BITS:0]   t_s3
);
	import cbz_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES:0]   load;
	logic [T_FRAC_BITS:0]  t_s1_q;
	logic [T_FRAC_BITS:0]  t_s2;
	logic [T_FRAC_BITS:0]  t_s3_q;

	// a stage takes new data when it is empty or its content moves on
	always_comb begin
		load[NUM_STAGES] = out_ready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// t above one saturates to one
	always_comb begin
		if (in_t[T_FRAC_BITS] && (|in_t[T_FRAC_BITS-1:0])) begin
			t_sat = {1'b1, {T_FRAC_BITS{1'b0}}};
		end else begin
			t_sat = in_t;
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			t_s1_q <= t_sat;
		end
		if (load[1]) begin
			t_s2 <= t_s1_q;
		end
		if (load[2]) begin
			t_s3_q <= t_s2;
		end
	end

	assign in_ready  = load[0];
	assign out_valid = valid_q[NUM_STAGES-1];
	assign ctl.load  = load[NUM_STAGES-1:0];
	assign t_s1      = t_s1_q;
	assign t_s3      = t_s3_q;

endmodule

`default_nettype wire

@@ sv/cbz_axis_pipe.sv @@
// ----------------------------------------------------------------------------
// cbz_axis_pipe
// De Casteljau datapath for one coordinate axis, three lerp levels in five
// register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_axis_pipe #(
	parameter int COORD_BITS  = 10,
	parameter int T_FRAC_BITS = 16
) (
	input  wire logic                                            clk,
	input  wire cbz_pkg::pipe_ctl_t                              ctl,
	input  wire logic [T_FRAC_BITS:0]                            t_sat,
	input  wire logic [T_FRAC_BITS:0]                            t_s1,
	input  wire logic [T_FRAC_BITS:0]                            t_s3,
	input  wire logic [cbz_pkg::NUM_CTRL_PTS-1:0][COORD_BITS-1:0] coord,
	output logic      [COORD_BITS-1:0]                           pixel
);
	import cbz_pkg::*;

	localparam int T_W  = T_FRAC_BITS + 1;
	localparam int B_W  = COORD_BITS + T_FRAC_BITS;
	localparam int D_W  = B_W + 1;
	localparam int M_W  = T_W + 1 + D_W;
	localparam int L1_W = T_W + 1 + COORD_BITS + 1;
	localparam logic [M_W-1:0] HALF_M = M_W'(1) << (T_FRAC_BITS - 1);
	localparam logic [B_W-1:0] HALF_B = B_W'(1) << (T_FRAC_BITS - 1);

	// stage 1
	logic signed [COORD_BITS:0] diff1 [NUM_CTRL_PTS-1];
	logic signed [L1_W-1:0]     prod1 [NUM_CTRL_PTS-1];
	logic signed [L1_W-1:0]     sum1  [NUM_CTRL_PTS-1];
	logic        [B_W-1:0]      b_s1  [NUM_CTRL_PTS-1];
	// stage 2
	logic signed [D_W-1:0]      diff2 [2];
	logic signed [M_W-1:0]      prod2 [2];
	logic signed [M_W-1:0]      prod_s2 [2];
	logic        [B_W-1:0]      b_s2  [2];
	// stage 3
	logic signed [M_W-1:0]      rsum3 [2];
	logic signed [M_W-1:0]      sum3  [2];
	logic        [B_W-1:0]      d_s3  [2];
	// stage 4
	logic signed [D_W-1:0]      diff4;
	logic signed [M_W-1:0]      prod4;
	logic signed [M_W-1:0]      prod_s4;
	logic        [B_W-1:0]      d_s4;
	// stage 5
	logic signed [M_W-1:0]      rsum5;
	logic signed [M_W-1:0]      sum5;
	logic        [B_W-1:0]      v5;
	logic        [B_W-1:0]      vr5;
	logic        [COORD_BITS-1:0] pix_s5;

	// first level works on whole pixels, so the lerp is exact: c0 * one + t * (c1 - c0)
	always_comb begin
		for (int i = 0; i < NUM_CTRL_PTS - 1; i++) begin
			diff1[i] = $signed({1'b0, coord[i+1]}) - $signed({1'b0, coord[i]});
			prod1[i] = L1_W'($signed({1'b0, t_sat})) * L1_W'(diff1[i]);
			sum1[i]  = $signed({3'b000, coord[i], {T_FRAC_BITS{1'b0}}}) + prod1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			for (int i = 0; i < NUM_CTRL_PTS - 1; i++) begin
				b_s1[i] <= sum1[i][B_W-1:0];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			diff2[j] = $signed({1'b0, b_s1[j+1]}) - $signed({1'b0, b_s1[j]});
			prod2[j] = M_W'($signed({1'b0, t_s1})) * M_W'(diff2[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			for (int j = 0; j < 2; j++) begin
				prod_s2[j] <= prod2[j];
				b_s2[j]    <= b_s1[j];
			end
		end
	end

	// a + round(t * (b - a)), the same as the weighted sum rounded half up
	always_comb begin
		for (int j = 0; j < 2; j++) begin
			rsum3[j] = prod_s2[j] + $signed(HALF_M);
			sum3[j]  = $signed({{(M_W - B_W){1'b0}}, b_s2[j]}) + (rsum3[j] >>> T_FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			for (int j = 0; j < 2; j++) begin
				d_s3[j] <= sum3[j][B_W-1:0];
			end
		end
	end

	always_comb begin
		diff4 = $signed({1'b0, d_s3[1]}) - $signed({1'b0, d_s3[0]});
		prod4 = M_W'($signed({1'b0, t_s3})) * M_W'(diff4);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			prod_s4 <= prod4;
			d_s4    <= d_s3[0];
		end
	end

	always_comb begin
		rsum5 = prod_s4 + $signed(HALF_M);
		sum5  = $signed({{(M_W - B_W){1'b0}}, d_s4}) + (rsum5 >>> T_FRAC_BITS);
		v5    = sum5[B_W-1:0];
		vr5   = v5 + HALF_B;
	end

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			pix_s5 <= vr5[T_FRAC_BITS +: COORD_BITS];
		end
	end

	assign pixel = pix_s5;

endmodule

`default_nettype wire

@@ sv/cubic_bezier_point_eval_top.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_top
// Cubic Bezier point evaluator. Each input item carries a curve parameter t
// (unsigned, T_FRAC_BITS fraction bits, values above one saturate to one) and
// gives one result item with the curve point rounded to the nearest pixel,
// computed by de Casteljau subdivision with rounded fixed-point lerps. The
// four control points are written through the cfg port (index 0..7 = p0_x,
// p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y); the user must write them only while
// no item is in flight, which the block itself does not enforce. Throughput is one
// item per clock while the output does not stall; the path has five register
// stages (one multiplier stage and one add stage per lerp level, the first level
// folded into one stage). Downstream back-pressure stalls only the stages that are full.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_eval_top #(
	parameter int COORD_BITS  = 10,
	parameter int T_FRAC_BITS = 16,
	localparam int S_TDATA_W  = ((T_FRAC_BITS + 1 + 7) / 8) * 8,
	localparam int M_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [cbz_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [COORD_BITS-1:0]             cfg_wdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [S_TDATA_W-1:0]              s_tdata,   // param_t, zero pad
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [M_TDATA_W-1:0]              m_tdata    // pixel_x, pixel_y, zero pad
);
	import cbz_pkg::*;

	logic [NUM_CTRL_PTS-1:0][COORD_BITS-1:0] ctrl_x;
	logic [NUM_CTRL_PTS-1:0][COORD_BITS-1:0] ctrl_y;
	pipe_ctl_t                               ctl;
	logic [T_FRAC_BITS:0]                    t_sat;
	logic [T_FRAC_BITS:0]                    t_s1;
	logic [T_FRAC_BITS:0]                    t_s3;
	logic [COORD_BITS-1:0]                   pixel_x;
	logic [COORD_BITS-1:0]                   pixel_y;

	cbz_cfg_regs #(
		.COORD_BITS(COORD_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.ctrl_x   (ctrl_x),
		.ctrl_y   (ctrl_y)
	);

	cbz_pipe_ctrl #(
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_t     (s_tdata[T_FRAC_BITS:0]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.ctl      (ctl),
		.t_sat    (t_sat),
		.t_s1     (t_s1),
		.t_s3     (t_s3)
	);

	cbz_axis_pipe #(
		.COORD_BITS (COORD_BITS),
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_axis_x (
		.clk  (clk),
		.ctl  (ctl),
		.t_sat(t_sat),
		.t_s1 (t_s1),
		.t_s3 (t_s3),
		.coord(ctrl_x),
		.pixel(pixel_x)
	);

	cbz_axis_pipe #(
		.COORD_BITS (COORD_BITS),
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_axis_y (
		.clk  (clk),
		.ctl  (ctl),
		.t_sat(t_sat),
		.t_s1 (t_s1),
		.t_s3 (t_s3),
		.coord(ctrl_y),
		.pixel(pixel_y)
	);

	assign m_tdata = M_TDATA_W'({pixel_y, pixel_x});

endmodule

`default_nettype wire

@@ sv/cbz_checker.sv @@
// ----------------------------------------------------------------------------
// cbz_checker
// Port-level checks of the Bezier evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_checker #(
	parameter int COORD_BITS  = 10,
	parameter int T_FRAC_BITS = 16,
	localparam int M_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);
	import cbz_pkg::*;

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the input side only stalls when every stage is full and the output blocked
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with room in the pipeline");

	// with the output free flowing an accepted item comes out once it has passed every stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_tvalid && s_tready, NUM_STAGES)
		&& $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) && $past(arst_n, 4)
		&& $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3)
		&& $past(m_tready, 4)
		|-> m_tvalid)
		else $error("item did not reach the output in time");

	// no output without some earlier accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, NUM_STAGES))
		else $error("result appeared without a matching item");

endmodule

bind cubic_bezier_point_eval_top cbz_checker #(
	.COORD_BITS (COORD_BITS),
	.T_FRAC_BITS(T_FRAC_BITS)
) u_cbz_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cubic Bezier point evaluator. Curve parameters
// stream in with random bursts and gaps while the result side stalls on its
// own pattern; each accepted parameter is turned into the expected pixel by a
// local de Casteljau evaluation and checked against the result stream in
// order. Control points are rewritten between drained phases.
// ----------------------------------------------------------------------------

module testbench;
	import cbz_pkg::*;

	localparam int  COORD_W      = 10;
	localparam int  T_W          = 17;
	localparam int  TDATA_W      = 24;
	localparam int  NUM_REGS     = 8;
	localparam int  RAND_SETS    = 12;
	localparam int  SET_ITEMS    = 124;
	localparam int  LONG_HOLD    = 200;
	localparam int  STALL_LIMIT  = 2000;
	localparam bit [63:0] T_ONE  = 64'd65536;
	localparam bit [63:0] T_HALF = 64'd32768;

	typedef struct packed {
		bit [COORD_W-1:0] y;
		bit [COORD_W-1:0] x;
	} pixel_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [COORD_W-1:0] cfg_wdata = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata   = '0;   // param_t, zero pad
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [TDATA_W-1:0] m_tdata;          // pixel_x, pixel_y, zero pad

	bit [COORD_W-1:0] ctrl_pt [NUM_REGS];
	bit [T_W-1:0]     param_queue [$];
	pixel_t           expected_pts [$];

	int  errors         = 0;
	int  params_sent    = 0;
	int  points_checked = 0;
	int  curve_sets     = 0;
	int  burst_left     = 0;
	int  gap_left       = 0;
	int  idle_cycles    = 0;
	bit  hold_request   = 1'b0;

	cubic_bezier_point_eval_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one rounded lerp step, 16 fraction bits, half up
	function automatic bit [63:0] lerp_round(bit [63:0] a, bit [63:0] b, bit [63:0] t);
		return ((T_ONE - t) * a + t * b + T_HALF) >> 16;
	endfunction

	function automatic bit [COORD_W-1:0] bezier_axis(bit [COORD_W-1:0] c0, bit [COORD_W-1:0] c1,
			bit [COORD_W-1:0] c2, bit [COORD_W-1:0] c3, bit [63:0] t);
		bit [63:0] b0, b1, b2, d0, d1, v, px;
		b0 = lerp_round(64'(c0) << 16, 64'(c1) << 16, t);
		b1 = lerp_round(64'(c1) << 16, 64'(c2) << 16, t);
		b2 = lerp_round(64'(c2) << 16, 64'(c3) << 16, t);
		d0 = lerp_round(b0, b1, t);
		d1 = lerp_round(b1, b2, t);
		v  = lerp_round(d0, d1, t);
		px = (v + T_HALF) >> 16;
		if (px > 64'd1023)
			px = 64'd1023;
		return px[COORD_W-1:0];
	endfunction

	function automatic pixel_t curve_point(bit [T_W-1:0] t_raw);
		bit [63:0] t;
		pixel_t    p;
		t   = (64'(t_raw) > T_ONE) ? T_ONE : 64'(t_raw);
		p.x = bezier_axis(ctrl_pt[REG_P0_X], ctrl_pt[REG_P1_X], ctrl_pt[REG_P2_X],
			ctrl_pt[REG_P3_X], t);
		p.y = bezier_axis(ctrl_pt[REG_P0_Y], ctrl_pt[REG_P1_Y], ctrl_pt[REG_P2_Y],
			ctrl_pt[REG_P3_Y], t);
		return p;
	endfunction

	function automatic bit [T_W-1:0] rand_param();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0:       return T_W'($urandom_range(65537, 131071));
			1:       return T_W'($urandom_range(0, 15));
			2:       return T_W'($urandom_range(65520, 65536));
			3:       return T_W'($urandom_range(32760, 32776));
			default: return T_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic bit [COORD_W-1:0] rand_coord(int style);
		case (style % 4)
			1:       return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
			2:       return COORD_W'($urandom_range(0, 3));
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// appends one curve parameter to the pending items
	task automatic queue_param(bit [T_W-1:0] t_val);
		param_queue = {param_queue, t_val};
	endtask

	// drives one register write; the write lands at the next rising edge
	task automatic set_reg(cfg_reg_t idx, bit [COORD_W-1:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		ctrl_pt[idx] = val;
	endtask

	task automatic end_cfg();
		@(posedge clk);
		cfg_wen <= 1'b0;
		curve_sets++;
	endtask

	// stimulus pauses here until every queued parameter is sent and every expected point has come back
	task automatic drain();
		while (param_queue.size() != 0 || s_tvalid || expected_pts.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// sender: bursts of random length, random gaps in between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_pts = {expected_pts, curve_point(s_tdata[T_W-1:0])};
				params_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (param_queue.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= TDATA_W'(param_queue.pop_front());
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern redrawn at random from four modes, plus one long hold on request
	int  rx_cycle;
	int  rx_mode;
	int  hold_left;
	bit  hold_taken;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			rx_cycle   = 0;
			rx_mode    = 0;
			hold_left  = 0;
			hold_taken = 1'b0;
		end else begin
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = LONG_HOLD;
			end
			if (!hold_request)
				hold_taken = 1'b0;
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= rx_cycle[0];
					2:       m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pts.size() == 0) begin
				errors++;
				$display("%0t: point x %0d y %0d arrived with none expected", $time,
					m_tdata[9:0], m_tdata[19:10]);
			end else begin
				want = expected_pts.pop_front();
				if (m_tdata[9:0] !== want.x) begin
					errors++;
					$display("%0t: pixel_x expected %0d got %0d", $time, want.x, m_tdata[9:0]);
				end
				if (m_tdata[19:10] !== want.y) begin
					errors++;
					$display("%0t: pixel_y expected %0d got %0d", $time, want.y, m_tdata[19:10]);
				end
				points_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d points outstanding", $time,
				idle_cycles, expected_pts.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_REGS; i++)
			ctrl_pt[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset control points, all zero
		queue_param(17'd0);
		queue_param(17'd65536);
		queue_param(17'd131071);
		drain();

		// zig-zag between the coordinate extremes
		set_reg(REG_P0_X, 10'd0);
		set_reg(REG_P0_Y, 10'd1023);
		set_reg(REG_P1_X, 10'd1023);
		set_reg(REG_P1_Y, 10'd0);
		set_reg(REG_P2_X, 10'd0);
		set_reg(REG_P2_Y, 10'd1023);
		set_reg(REG_P3_X, 10'd1023);
		set_reg(REG_P3_Y, 10'd0);
		end_cfg();
		// ends, midpoint, one step either side, above one, alternating bits
		queue_param(17'd0);
		queue_param(17'd1);
		queue_param(17'd2);
		queue_param(17'd32767);
		queue_param(17'd32768);
		queue_param(17'd32769);
		queue_param(17'd65534);
		queue_param(17'd65535);
		queue_param(17'd65536);
		queue_param(17'd65537);
		queue_param(17'd98304);
		queue_param(17'd131071);
		queue_param(17'd87381);
		queue_param(17'd43690);
		drain();

		// every coordinate at full scale
		for (int i = 0; i < NUM_REGS; i++)
			set_reg(cfg_reg_t'(i), 10'd1023);
		end_cfg();
		queue_param(17'd0);
		queue_param(17'd32768);
		queue_param(17'd65536);
		queue_param(17'd131071);
		drain();

		for (int s = 0; s < RAND_SETS; s++) begin
			for (int i = 0; i < NUM_REGS; i++)
				set_reg(cfg_reg_t'(i), rand_coord(s));
			end_cfg();
			// result side holds off for a long stretch in one set
			if (s == 2)
				hold_request = 1'b1;
			for (int n = 0; n < SET_ITEMS; n++)
				queue_param(rand_param());
			drain();
			hold_request = 1'b0;
		end

		repeat (4 * NUM_STAGES) @(posedge clk);
		if (expected_pts.size() != 0) begin
			errors++;
			$display("%0t: %0d expected points never arrived", $time, expected_pts.size());
		end
		$display("covered %0d curve parameters over %0d control-point sets,", params_sent,
			curve_sets + 1);
		$display("%0d points compared, %0d field errors", points_checked, errors);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
